// ===== hw/rtl/nrpn_cc_pkg.sv =====
package nrpn_cc_pkg;

   localparam int unsigned IndexWidth = 14;
   localparam int unsigned ValueWidth = 15;
   localparam int unsigned ByteWidth  = 7;
   localparam int unsigned ReqDataWidth = 32;
   localparam int unsigned RspDataWidth = 16;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 2;
   localparam int unsigned QueueDepth = 4;

   // controller numbers
   localparam logic [ByteWidth-1:0] CcSelMsb = 7'd99;
   localparam logic [ByteWidth-1:0] CcSelLsb = 7'd98;
   localparam logic [ByteWidth-1:0] CcDatMsb = 7'd6;
   localparam logic [ByteWidth-1:0] CcDatLsb = 7'd38;

   // value_mode codes
   localparam logic [1:0] ModeTwos     = 2'd0;
   localparam logic [1:0] ModeFourteen = 2'd1;

   // csr indexes
   localparam logic [CsrIndexWidth-1:0] CsrFilterMsb = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrValueMode = 2'd1;

   // positions in the pending-message mask
   localparam int unsigned MsgSelMsb = 0;
   localparam int unsigned MsgSelLsb = 1;
   localparam int unsigned MsgDatMsb = 2;
   localparam int unsigned MsgDatLsb = 3;
   localparam int unsigned MsgCount  = 4;

   typedef struct packed {
      logic                 send_sel_msb;
      logic                 send_sel_lsb;
      logic                 send_dat_msb;
      logic [ByteWidth-1:0] idx_msb;
      logic [ByteWidth-1:0] idx_lsb;
      logic [ByteWidth-1:0] dat_msb;
      logic [ByteWidth-1:0] dat_lsb;
   } job_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

// ===== hw/rtl/nrpn_to_cc_encoder_unit.sv =====
// NRPN to MIDI control-change encoder.
// req channel: one beat per NRPN item, tdata = param_index [13:0], param_value [28:14]
// (signed), zero pad above. Every beat is taken while the job queue has room.
// rsp channel: one beat per CC message, tdata = cc_number [6:0], cc_value [13:7];
// tlast marks the CC 38 beat that closes the run of one item.
// csr channel: csr_index 0 = filter_msb, 1 = value_mode; always ready, other
// indexes ignored. Write only while the block is idle.
// A req beat passes the queue entry, the job register and the output register
// before its first rsp beat can appear.
// Throughput: one rsp beat per cycle while rsp_tready is high and jobs are queued;
// an item causes 1 to 4 CC messages, each through the single output register.
// Items in invalid mode are taken and produce no beats.
// The front end tracks sent index / data MSB at accept time and queues jobs
// (Depth entries); a stalled rsp fills the queue, then req_tready drops.
// Reset: queue and output empty, filter_msb = 1, value_mode = 0, no index or
// MSB counted as sent.
module nrpn_to_cc_encoder_unit #(
   parameter int unsigned QueueDepth = nrpn_cc_pkg::QueueDepth
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [nrpn_cc_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [nrpn_cc_pkg::CsrDataWidth-1:0]      csr_data,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // param_index [13:0], param_value [28:14], zero [31:29]
   input  logic [nrpn_cc_pkg::ReqDataWidth-1:0]      req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // cc_number [6:0], cc_value [13:7], zero [15:14]
   output logic [nrpn_cc_pkg::RspDataWidth-1:0]      rsp_tdata,
   output logic                                      rsp_tlast
);

   logic                          push_valid;
   nrpn_cc_pkg::job_type          push_job;
   nrpn_cc_pkg::job_type          q_job;
   nrpn_cc_pkg::queue_status_type q_status;
   logic                          q_pop;

   assign csr_ready = 1'b1;

   nrpn_cc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   nrpn_cc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (q_pop),
      .pop_job    (q_job),
      .status     (q_status)
   );

   nrpn_cc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_job      (q_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hw/rtl/nrpn_cc_front.sv =====
module nrpn_cc_front (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_valid,
   input  logic [nrpn_cc_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [nrpn_cc_pkg::CsrDataWidth-1:0]      csr_data,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [nrpn_cc_pkg::ReqDataWidth-1:0]      req_tdata,
   input  nrpn_cc_pkg::queue_status_type             q_status,
   output logic                                      push_valid,
   output nrpn_cc_pkg::job_type                      push_job
);

   logic                                   filter_ff, filter_in;
   logic [1:0]                             mode_ff, mode_in;
   logic [nrpn_cc_pkg::IndexWidth-1:0]     sent_index_ff, sent_index_in;
   logic                                   sent_index_valid_ff, sent_index_valid_in;
   logic [nrpn_cc_pkg::ByteWidth-1:0]      sent_msb_ff, sent_msb_in;
   logic                                   sent_msb_valid_ff, sent_msb_valid_in;

   logic [nrpn_cc_pkg::IndexWidth-1:0]     idx;
   logic [nrpn_cc_pkg::ValueWidth-1:0]     raw;
   logic [nrpn_cc_pkg::ByteWidth-1:0]      dmsb;
   logic                                   mode_ok;
   logic                                   accept;
   logic                                   idx_change;
   logic                                   msb_known;

   assign idx = req_tdata[nrpn_cc_pkg::IndexWidth-1:0];
   assign raw = req_tdata[nrpn_cc_pkg::IndexWidth +: nrpn_cc_pkg::ValueWidth];

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      mode_ok = 1'b1;
      dmsb    = raw[13:7];
      case (mode_ff)
         nrpn_cc_pkg::ModeTwos: begin
            if (raw[nrpn_cc_pkg::ValueWidth-1]) begin
               dmsb = 7'd1;
            end
         end
         nrpn_cc_pkg::ModeFourteen: begin
            dmsb = raw[13:7];
         end
         default: begin
            mode_ok = 1'b0;
         end
      endcase
   end

   assign idx_change = !sent_index_valid_ff || (sent_index_ff != idx);
   assign msb_known  = !idx_change && sent_msb_valid_ff;

   always_comb begin
      push_job.send_sel_lsb = idx_change;
      push_job.send_sel_msb = idx_change && (!filter_ff || (idx[13:7] != 7'd0));
      push_job.send_dat_msb = !filter_ff || !msb_known || (sent_msb_ff != dmsb);
      push_job.idx_msb      = idx[13:7];
      push_job.idx_lsb      = idx[6:0];
      push_job.dat_msb      = dmsb;
      push_job.dat_lsb      = raw[6:0];
   end

   assign push_valid = accept && mode_ok;

   always_comb begin
      filter_in           = filter_ff;
      mode_in             = mode_ff;
      sent_index_in       = sent_index_ff;
      sent_index_valid_in = sent_index_valid_ff;
      sent_msb_in         = sent_msb_ff;
      sent_msb_valid_in   = sent_msb_valid_ff;
      if (csr_valid) begin
         case (csr_index)
            nrpn_cc_pkg::CsrFilterMsb: filter_in = csr_data[0];
            nrpn_cc_pkg::CsrValueMode: mode_in   = csr_data[1:0];
            default: begin
            end
         endcase
      end
      if (push_valid) begin
         sent_index_in       = idx;
         sent_index_valid_in = 1'b1;
         sent_msb_in         = dmsb;
         sent_msb_valid_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff           <= 1'b1;
         mode_ff             <= nrpn_cc_pkg::ModeTwos;
         sent_index_ff       <= '0;
         sent_index_valid_ff <= 1'b0;
         sent_msb_ff         <= '0;
         sent_msb_valid_ff   <= 1'b0;
      end else begin
         filter_ff           <= filter_in;
         mode_ff             <= mode_in;
         sent_index_ff       <= sent_index_in;
         sent_index_valid_ff <= sent_index_valid_in;
         sent_msb_ff         <= sent_msb_in;
         sent_msb_valid_ff   <= sent_msb_valid_in;
      end
   end

   // a new index always re-sends the data MSB
   assert property (@(posedge clock) disable iff (reset)
      push_valid && idx_change |-> push_job.send_dat_msb && push_job.send_sel_lsb)
      else $error("index change without select and data MSB");

   assert property (@(posedge clock) disable iff (reset)
      push_valid |=> sent_index_valid_ff && sent_msb_valid_ff)
      else $error("sent state not marked after beat");

   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !q_status.full)
      else $error("push into full queue");

endmodule

// ===== hw/rtl/nrpn_cc_queue.sv =====
module nrpn_cc_queue #(
   parameter int unsigned Depth = nrpn_cc_pkg::QueueDepth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   input  nrpn_cc_pkg::job_type          push_job,
   input  logic                          pop,
   output nrpn_cc_pkg::job_type          pop_job,
   output nrpn_cc_pkg::queue_status_type status
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   nrpn_cc_pkg::job_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign status.full  = (count_ff == CntW'(Depth));
   assign status.valid = (count_ff != '0);
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop && status.valid;
   assign pop_job      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count overflow");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> status.valid)
      else $error("pop from empty queue");

   assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff == rd_ptr_ff) |-> (count_ff == '0 || status.full))
      else $error("queue pointers disagree with count");

endmodule

// ===== hw/rtl/nrpn_cc_back.sv =====
module nrpn_cc_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  nrpn_cc_pkg::queue_status_type         q_status,
   input  nrpn_cc_pkg::job_type                  q_job,
   output logic                                  q_pop,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [nrpn_cc_pkg::RspDataWidth-1:0]  rsp_tdata,
   output logic                                  rsp_tlast
);

   localparam int unsigned MsgCount = nrpn_cc_pkg::MsgCount;

   nrpn_cc_pkg::job_type               job_ff, job_in;
   logic                               job_valid_ff, job_valid_in;
   logic [MsgCount-1:0]                mask_ff, mask_in;
   logic                               out_valid_ff, out_valid_in;
   logic [nrpn_cc_pkg::ByteWidth-1:0]  out_number_ff, out_number_in;
   logic [nrpn_cc_pkg::ByteWidth-1:0]  out_value_ff, out_value_in;
   logic                               out_last_ff, out_last_in;

   logic                               advance;
   logic                               emit;
   logic                               is_last;
   logic [MsgCount-1:0]                pick;
   logic [nrpn_cc_pkg::ByteWidth-1:0]  pick_number;
   logic [nrpn_cc_pkg::ByteWidth-1:0]  pick_value;

   assign advance = !out_valid_ff || rsp_tready;
   assign emit    = advance && job_valid_ff;
   assign pick    = mask_ff & (~mask_ff + 1'b1);
   assign is_last = pick[nrpn_cc_pkg::MsgDatLsb];
   assign q_pop   = q_status.valid && (!job_valid_ff || (emit && is_last));

   always_comb begin
      pick_number = nrpn_cc_pkg::CcDatLsb;
      pick_value  = job_ff.dat_lsb;
      if (pick[nrpn_cc_pkg::MsgSelMsb]) begin
         pick_number = nrpn_cc_pkg::CcSelMsb;
         pick_value  = job_ff.idx_msb;
      end else if (pick[nrpn_cc_pkg::MsgSelLsb]) begin
         pick_number = nrpn_cc_pkg::CcSelLsb;
         pick_value  = job_ff.idx_lsb;
      end else if (pick[nrpn_cc_pkg::MsgDatMsb]) begin
         pick_number = nrpn_cc_pkg::CcDatMsb;
         pick_value  = job_ff.dat_msb;
      end
   end

   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      mask_in      = mask_ff;
      if (q_pop) begin
         job_in       = q_job;
         job_valid_in = 1'b1;
         mask_in[nrpn_cc_pkg::MsgSelMsb] = q_job.send_sel_msb;
         mask_in[nrpn_cc_pkg::MsgSelLsb] = q_job.send_sel_lsb;
         mask_in[nrpn_cc_pkg::MsgDatMsb] = q_job.send_dat_msb;
         mask_in[nrpn_cc_pkg::MsgDatLsb] = 1'b1;
      end else if (emit) begin
         mask_in = mask_ff & ~pick;
         if (is_last) begin
            job_valid_in = 1'b0;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_number_in = out_number_ff;
      out_value_in  = out_value_ff;
      out_last_in   = out_last_ff;
      if (advance) begin
         out_valid_in = job_valid_ff;
      end
      if (emit) begin
         out_number_in = pick_number;
         out_value_in  = pick_value;
         out_last_in   = is_last;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      out_number_ff <= out_number_in;
      out_value_ff  <= out_value_in;
      out_last_ff   <= out_last_in;
      if (reset) begin
         job_valid_ff <= 1'b0;
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(nrpn_cc_pkg::RspDataWidth - 2 * nrpn_cc_pkg::ByteWidth){1'b0}},
                        out_value_ff, out_number_ff};

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (out_number_ff == nrpn_cc_pkg::CcDatLsb)))
      else $error("tlast not on data LSB beat");

   assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> mask_ff[nrpn_cc_pkg::MsgDatLsb])
      else $error("active job lost its closing beat");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !job_valid_ff)
      else $error("output live after reset");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

   localparam logic [1:0] ModeInvalid  = 2'd2;
   localparam logic [1:0] ModeReserved = 2'd3;
   localparam logic [nrpn_cc_pkg::CsrIndexWidth-1:0] CsrSpareA = 2'd2;
   localparam logic [nrpn_cc_pkg::CsrIndexWidth-1:0] CsrSpareB = 2'd3;
   localparam int unsigned StallLimit = 1000;
   localparam int unsigned LongHold   = 100;
   localparam int unsigned SettleCycles = 8;

   typedef struct packed {
      logic [nrpn_cc_pkg::ByteWidth-1:0] number;
      logic [nrpn_cc_pkg::ByteWidth-1:0] data;
      logic                              closes;
   } cc_msg_type;

   class cc_run_scoreboard_type;
      logic                               filter_on;
      logic [1:0]                         mode;
      logic [nrpn_cc_pkg::IndexWidth-1:0] last_index;
      logic                               index_known;
      logic [nrpn_cc_pkg::ByteWidth-1:0]  last_dmsb;
      logic                               dmsb_known;
      cc_msg_type                         due[$];
      int                                 failures;

      function new();
         filter_on   = 1'b1;
         mode        = nrpn_cc_pkg::ModeTwos;
         last_index  = '0;
         index_known = 1'b0;
         last_dmsb   = '0;
         dmsb_known  = 1'b0;
         failures    = 0;
      endfunction

      function void set_reg(logic [nrpn_cc_pkg::CsrIndexWidth-1:0] idx,
                            logic [nrpn_cc_pkg::CsrDataWidth-1:0] data);
         case (idx)
            nrpn_cc_pkg::CsrFilterMsb: begin
               filter_on = data[0];
            end
            nrpn_cc_pkg::CsrValueMode: begin
               mode = data[1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function int pending();
         return due.size();
      endfunction

      // expected CC run for one accepted item
      function void note_item(logic [nrpn_cc_pkg::IndexWidth-1:0] idx,
                              logic [nrpn_cc_pkg::ValueWidth-1:0] val);
         logic [nrpn_cc_pkg::ByteWidth-1:0] dmsb;
         logic [nrpn_cc_pkg::ByteWidth-1:0] dlsb;
         logic [nrpn_cc_pkg::ByteWidth-1:0] imsb;
         if (mode == nrpn_cc_pkg::ModeTwos) begin
            dmsb = val[nrpn_cc_pkg::ValueWidth-1] ? 7'd1 : val[13:7];
            dlsb = val[6:0];
         end else if (mode == nrpn_cc_pkg::ModeFourteen) begin
            dmsb = val[13:7];
            dlsb = val[6:0];
         end else begin
            return;
         end
         if (!index_known || last_index != idx) begin
            imsb = idx[13:7];
            dmsb_known = 1'b0;
            if (!filter_on || imsb != '0)
               due.push_back('{nrpn_cc_pkg::CcSelMsb, imsb, 1'b0});
            due.push_back('{nrpn_cc_pkg::CcSelLsb, idx[6:0], 1'b0});
            last_index  = idx;
            index_known = 1'b1;
         end
         if (!filter_on || !dmsb_known || last_dmsb != dmsb)
            due.push_back('{nrpn_cc_pkg::CcDatMsb, dmsb, 1'b0});
         due.push_back('{nrpn_cc_pkg::CcDatLsb, dlsb, 1'b1});
         last_dmsb  = dmsb;
         dmsb_known = 1'b1;
      endfunction

      function void check_msg(logic [nrpn_cc_pkg::ByteWidth-1:0] number,
                              logic [nrpn_cc_pkg::ByteWidth-1:0] data,
                              logic closes);
         cc_msg_type want;
         if (due.size() == 0) begin
            $display("%0t: unexpected beat cc_number %0d cc_value %0d tlast %0b",
                     $time, number, data, closes);
            failures++;
            return;
         end
         want = due.pop_front();
         if (want.number != number) begin
            $display("%0t: cc_number expected %0d, got %0d", $time, want.number, number);
            failures++;
         end
         if (want.data != data) begin
            $display("%0t: cc_value expected %0d, got %0d", $time, want.data, data);
            failures++;
         end
         if (want.closes != closes) begin
            $display("%0t: tlast expected %0b, got %0b", $time, want.closes, closes);
            failures++;
         end
      endfunction
   endclass

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  csr_valid;
   logic                                  csr_ready;
   logic [nrpn_cc_pkg::CsrIndexWidth-1:0] csr_index;
   logic [nrpn_cc_pkg::CsrDataWidth-1:0]  csr_data;
   logic                                  req_tvalid;
   logic                                  req_tready;
   logic [nrpn_cc_pkg::ReqDataWidth-1:0]  req_tdata;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready;
   logic [nrpn_cc_pkg::RspDataWidth-1:0]  rsp_tdata;
   logic                                  rsp_tlast;

   cc_run_scoreboard_type board = new();
   bit quiet     = 1'b0;
   bit long_hold = 1'b0;

   always #1 clock = ~clock;

   nrpn_to_cc_encoder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   task automatic send_item(input logic [nrpn_cc_pkg::IndexWidth-1:0] idx,
                            input logic [nrpn_cc_pkg::ValueWidth-1:0] val);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(nrpn_cc_pkg::ReqDataWidth - nrpn_cc_pkg::IndexWidth
                       - nrpn_cc_pkg::ValueWidth){1'b0}}, val, idx};
      do @(posedge clock); while (!req_tready);
      board.note_item(idx, val);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // block must be drained before a register write
   task automatic csr_write(input logic [nrpn_cc_pkg::CsrIndexWidth-1:0] idx,
                            input logic [nrpn_cc_pkg::CsrDataWidth-1:0] data);
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, data);
      csr_valid <= 1'b0;
   endtask

   task automatic run_items(input int count);
      logic [nrpn_cc_pkg::IndexWidth-1:0] pool [4];
      logic [nrpn_cc_pkg::ByteWidth-1:0]  msb_pool;
      logic [nrpn_cc_pkg::IndexWidth-1:0] idx;
      logic [nrpn_cc_pkg::ValueWidth-1:0] val;
      pool[0]  = nrpn_cc_pkg::IndexWidth'($urandom_range(0, 127));
      pool[1]  = nrpn_cc_pkg::IndexWidth'($urandom);
      pool[2]  = nrpn_cc_pkg::IndexWidth'($urandom);
      pool[3]  = nrpn_cc_pkg::IndexWidth'($urandom_range(16256, 16383));
      msb_pool = nrpn_cc_pkg::ByteWidth'($urandom);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 7)
            idx = pool[2'($urandom_range(0, 3))];
         else
            idx = nrpn_cc_pkg::IndexWidth'($urandom);
         case ($urandom_range(0, 4))
            0: val = nrpn_cc_pkg::ValueWidth'($urandom);
            1: val = nrpn_cc_pkg::ValueWidth'(-int'($urandom_range(1, 128)));
            2: val = {1'b0, msb_pool, nrpn_cc_pkg::ByteWidth'($urandom)};
            3: val = {1'b0, 7'd1, nrpn_cc_pkg::ByteWidth'($urandom)};
            default: val = {1'b0, nrpn_cc_pkg::IndexWidth'($urandom)};
         endcase
         send_item(idx, val);
      end
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      stall = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            board.check_msg(rsp_tdata[6:0], rsp_tdata[13:7], rsp_tlast);
         if (long_hold) begin
            long_hold = 1'b0;
            stall = LongHold;
         end else if (stall == 0 && !quiet && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 9);
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= StallLimit) begin
            $display("%0t: no beat accepted for %0d cycles", $time, StallLimit);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      reset      <= 1'b1;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: filter on, two's complement
      send_item(14'd0, 15'd0);
      send_item(14'd0, 15'd5);
      send_item(14'd0, 15'd16383);
      send_item(14'd16383, 15'h7fff);
      send_item(14'd16383, 15'h7f80);
      send_item(14'd16383, 15'h4000);
      send_item(14'd128, 15'd128);
      csr_write(nrpn_cc_pkg::CsrFilterMsb, 2'd0);
      send_item(14'd128, 15'd128);
      send_item(14'd5, 15'd0);
      csr_write(nrpn_cc_pkg::CsrValueMode, nrpn_cc_pkg::ModeFourteen);
      send_item(14'd5, 15'h7fff);
      send_item(14'd5, 15'd16383);
      send_item(14'd5, 15'h4000);
      // invalid modes: no beats, state kept
      csr_write(nrpn_cc_pkg::CsrValueMode, ModeInvalid);
      send_item(14'd77, 15'd99);
      csr_write(nrpn_cc_pkg::CsrValueMode, ModeReserved);
      send_item(14'd9, 15'h7fff);
      csr_write(CsrSpareA, 2'd3);
      csr_write(CsrSpareB, 2'd3);
      csr_write(nrpn_cc_pkg::CsrValueMode, nrpn_cc_pkg::ModeFourteen);
      send_item(14'd5, 15'd0);
      csr_write(nrpn_cc_pkg::CsrFilterMsb, 2'd2);
      send_item(14'd5, 15'd0);
      csr_write(nrpn_cc_pkg::CsrFilterMsb, 2'd3);
      send_item(14'd5, 15'd0);
      send_item(14'd6, 15'd0);

      csr_write(nrpn_cc_pkg::CsrValueMode, nrpn_cc_pkg::ModeTwos);
      long_hold = 1'b1;
      run_items(90);
      csr_write(nrpn_cc_pkg::CsrFilterMsb, 2'd0);
      run_items(80);
      csr_write(nrpn_cc_pkg::CsrFilterMsb, 2'd1);
      csr_write(nrpn_cc_pkg::CsrValueMode, nrpn_cc_pkg::ModeFourteen);
      run_items(80);
      csr_write(nrpn_cc_pkg::CsrFilterMsb, 2'd0);
      run_items(80);
      csr_write(nrpn_cc_pkg::CsrFilterMsb, 2'd1);
      csr_write(nrpn_cc_pkg::CsrValueMode, ModeInvalid);
      run_items(12);
      csr_write(nrpn_cc_pkg::CsrValueMode, ModeReserved);
      run_items(8);
      csr_write(nrpn_cc_pkg::CsrValueMode, nrpn_cc_pkg::ModeTwos);
      run_items(60);
      csr_write(nrpn_cc_pkg::CsrValueMode, nrpn_cc_pkg::ModeFourteen);
      quiet = 1'b1;
      run_items(60);

      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/nrpn_cc_pkg.sv
hw/rtl/nrpn_cc_front.sv
hw/rtl/nrpn_cc_queue.sv
hw/rtl/nrpn_cc_back.sv
hw/rtl/nrpn_to_cc_encoder_unit.sv
test/testbench.sv
